// File: rtl/core/dfmi_pkg.sv
package dfmi_pkg;

    // Filter length and derived widths
    localparam int TAPS    = 11;
    localparam int TAP_AW  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FILL_W  = $clog2(TAPS + 1);
    localparam int MAC_KW  = $clog2(TAPS + 2);

    // Fixed field and datapath widths
    localparam int FREQ_W  = 16;
    localparam int CFG_W   = 16;
    localparam int DIFF_W  = 18;
    localparam int TAP_W   = 16;
    localparam int MUL_AW  = 18;
    localparam int MUL_BW  = 17;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int ACC_W   = 36;
    localparam int RATE_W  = 16;
    localparam int VOL_W   = 32;
    localparam int CFG_AW  = 3;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_SAMPLE    = 2'd0;
    localparam logic [1:0] OP_NO_SAMPLE = 2'd1;
    localparam logic [1:0] OP_CLR_VOL   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_OFF_THR   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ON_THR    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_REJECT    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_IN_GAIN   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_RET_GAIN  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_TIME_STEP = 3'd5;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCALE_RET,
        ST_WRITE,
        ST_MAC,
        ST_ROUND,
        ST_VOL_MUL,
        ST_VOL_ADD,
        ST_FINISH
    } state_t;

    // Q1.15 low-pass taps, tap k weighs the k-th newest sample
    function automatic logic signed [TAP_W-1:0] tap_coef(input logic [TAP_AW-1:0] idx);
        logic signed [TAP_W-1:0] c;
        case (int'(idx))
            0:       c = -16'sd582;
            1:       c = -16'sd766;
            2:       c = 16'sd715;
            3:       c = 16'sd4454;
            4:       c = 16'sd8776;
            5:       c = 16'sd10714;
            6:       c = 16'sd8776;
            7:       c = 16'sd4454;
            8:       c = 16'sd715;
            9:       c = -16'sd766;
            10:      c = -16'sd582;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/dfmi_ram.sv
// Single write port, single registered read port
module dfmi_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 11
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/dual_flow_meter_integrator.sv
// Accept to m_tvalid: no-sample, volume clear, unused and rejected ops pass EVAL and FINISH; a
// sample while the delay line fills passes EVAL, SCALE_RET, WRITE, FINISH; a filtered sample adds
// MAC, ROUND, VOL_MUL, VOL_ADD before FINISH. One item at a time: the next transfer is taken no
// earlier than the cycle after the result is registered; a filtered sample is paced by the single
// shared multiplier walking the delay-line RAM one tap per cycle. Reset (aresetn low, synchronous)
// clears flags, rate, volume, fill count and restores register defaults; RAM needs no clearing.
module dual_flow_meter_integrator
    import dfmi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [15:0] inlet_freq, [31:16] return_freq
    input  logic [1:0]        s_tuser,   // [1:0] op
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,   // [15:0] flow_rate, [47:16] flow_volume, [48] flowing
    output logic [0:0]        m_tuser,   // [0] rate_valid
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_data
);

    // Control state
    state_t                    state_reg, state_next;
    logic [TAP_AW-1:0]         head_reg, head_next;
    logic [TAP_AW-1:0]         rptr_reg, rptr_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic [MAC_KW-1:0]         k_reg, k_next;
    logic                      flowing_reg, flowing_next;
    logic                      valid_reg, valid_next;
    logic signed [RATE_W-1:0]  rate_reg, rate_next;
    logic signed [VOL_W-1:0]   volume_reg, volume_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // Configuration registers
    logic [CFG_W-1:0] off_thr_reg, on_thr_reg, reject_reg;
    logic [CFG_W-1:0] in_gain_reg, ret_gain_reg, tstep_reg;

    // Item and datapath registers
    logic [1:0]                op_reg;
    logic [FREQ_W-1:0]         fin_reg, fret_reg;
    logic [FREQ_W:0]           scaled_in_reg, scaled_in_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [55:0]               m_tdata_reg;
    logic                      m_tuser_reg;

    // Shared multiplier operands
    logic signed [MUL_AW-1:0]  mul_a;
    logic signed [MUL_BW-1:0]  mul_b;

    // RAM port
    logic                      ram_we, ram_re;
    logic [DIFF_W-1:0]         ram_wdata, ram_rdata;
    logic [TAP_AW-1:0]         ram_raddr;

    // Arithmetic helpers
    logic signed [PROD_W-1:0]  prod_round;
    logic [FREQ_W:0]           scaled_ret;
    logic signed [ACC_W-1:0]   acc_round;
    logic signed [ACC_W-16:0]  rate_wide;
    logic signed [PROD_W-17:0] vol_delta;
    logic signed [VOL_W:0]     vol_sum;
    logic [MAC_KW-1:0]         tap_k;
    logic [FILL_W-1:0]         fill_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Rounding taps off the registered product
    assign prod_round = prod_reg + PROD_W'(32768);
    assign scaled_ret = prod_round[FREQ_W+16:16];
    assign vol_delta  = prod_round[PROD_W-1:16];
    assign acc_round  = acc_reg + ACC_W'(16384);
    assign rate_wide  = acc_round[ACC_W-1:15];
    assign vol_sum    = {volume_reg[VOL_W-1], volume_reg}
                      + {{(VOL_W + 1 - (PROD_W - 16)){vol_delta[PROD_W-17]}}, vol_delta};
    assign tap_k      = k_reg - MAC_KW'(1);
    assign fill_inc   = (fill_reg < FILL_W'(TAPS)) ? fill_reg + FILL_W'(1) : fill_reg;

    dfmi_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (head_next),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state and datapath control
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        rptr_next      = rptr_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        flowing_next   = flowing_reg;
        valid_next     = valid_reg;
        rate_next      = rate_reg;
        volume_next    = volume_reg;
        m_tvalid_next  = m_tvalid_reg;
        scaled_in_next = scaled_in_reg;
        acc_next       = acc_reg;
        mul_a          = '0;
        mul_b          = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = rptr_reg;
        ram_wdata      = DIFF_W'({1'b0, scaled_in_reg}) - DIFF_W'({1'b0, scaled_ret});

        // result register drains independently
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL: begin
                state_next = ST_FINISH;
                case (op_reg)
                    OP_SAMPLE: begin
                        if (fin_reg < reject_reg) begin
                            if (flowing_reg && fin_reg < off_thr_reg) begin
                                flowing_next = 1'b0;
                            end else if (!flowing_reg && fin_reg > on_thr_reg) begin
                                flowing_next = 1'b1;
                            end
                            mul_a      = MUL_AW'({2'b00, fin_reg});
                            mul_b      = MUL_BW'({1'b0, in_gain_reg});
                            state_next = ST_SCALE_RET;
                        end
                    end
                    OP_NO_SAMPLE: begin
                        valid_next   = 1'b0;
                        flowing_next = 1'b0;
                    end
                    OP_CLR_VOL: begin
                        volume_next = '0;
                    end
                    default: begin
                    end
                endcase
            end

            ST_SCALE_RET: begin
                scaled_in_next = scaled_ret;
                mul_a          = MUL_AW'({2'b00, fret_reg});
                mul_b          = MUL_BW'({1'b0, ret_gain_reg});
                state_next     = ST_WRITE;
            end

            // write the new difference at the advanced head
            ST_WRITE: begin
                head_next = (head_reg == TAP_AW'(TAPS - 1)) ? '0 : head_reg + TAP_AW'(1);
                ram_we    = 1'b1;
                fill_next = fill_inc;
                rptr_next = head_next;
                k_next    = '0;
                acc_next  = '0;
                if (fill_inc == FILL_W'(TAPS)) begin
                    state_next = ST_MAC;
                end else begin
                    state_next = ST_FINISH;
                end
            end

            // read newest-first, multiply in the next cycle, accumulate in the cycle after that
            ST_MAC: begin
                if (k_reg < MAC_KW'(TAPS)) begin
                    ram_re    = 1'b1;
                    rptr_next = (rptr_reg == '0) ? TAP_AW'(TAPS - 1) : rptr_reg - TAP_AW'(1);
                end
                if (k_reg >= MAC_KW'(1)) begin
                    mul_a = ram_rdata;
                    mul_b = MUL_BW'(tap_coef(tap_k[TAP_AW-1:0]));
                end
                if (k_reg >= MAC_KW'(2)) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                k_next = k_reg + MAC_KW'(1);
                if (k_reg == MAC_KW'(TAPS + 1)) begin
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND: begin
                if (rate_wide > (ACC_W-15)'(32767)) begin
                    rate_next = 16'sh7FFF;
                end else if (rate_wide < -(ACC_W-15)'(32768)) begin
                    rate_next = 16'sh8000;
                end else begin
                    rate_next = rate_wide[RATE_W-1:0];
                end
                state_next = ST_VOL_MUL;
            end

            ST_VOL_MUL: begin
                mul_a      = MUL_AW'(rate_reg);
                mul_b      = MUL_BW'({1'b0, tstep_reg});
                state_next = ST_VOL_ADD;
            end

            // saturating volume update
            ST_VOL_ADD: begin
                if (vol_sum[VOL_W] != vol_sum[VOL_W-1]) begin
                    volume_next = vol_sum[VOL_W] ? {1'b1, {(VOL_W-1){1'b0}}}
                                                 : {1'b0, {(VOL_W-1){1'b1}}};
                end else begin
                    volume_next = vol_sum[VOL_W-1:0];
                end
                valid_next = 1'b1;
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            rptr_reg     <= '0;
            fill_reg     <= '0;
            k_reg        <= '0;
            flowing_reg  <= 1'b0;
            valid_reg    <= 1'b0;
            rate_reg     <= '0;
            volume_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            rptr_reg     <= rptr_next;
            fill_reg     <= fill_next;
            k_reg        <= k_next;
            flowing_reg  <= flowing_next;
            valid_reg    <= valid_next;
            rate_reg     <= rate_next;
            volume_reg   <= volume_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_thr_reg  <= 16'd64;
            on_thr_reg   <= 16'd320;
            reject_reg   <= 16'd19200;
            in_gain_reg  <= 16'd8192;
            ret_gain_reg <= 16'd9101;
            tstep_reg    <= 16'd6554;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_OFF_THR:   off_thr_reg  <= cfg_data;
                REG_ON_THR:    on_thr_reg   <= cfg_data;
                REG_REJECT:    reject_reg   <= cfg_data;
                REG_IN_GAIN:   in_gain_reg  <= cfg_data;
                REG_RET_GAIN:  ret_gain_reg <= cfg_data;
                REG_TIME_STEP: tstep_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_reg      <= mul_a * mul_b;
        acc_reg       <= acc_next;
        scaled_in_reg <= scaled_in_next;
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tuser;
            fin_reg  <= s_tdata[15:0];
            fret_reg <= s_tdata[31:16];
        end
        if (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {7'd0, flowing_reg, volume_reg, rate_reg};
            m_tuser_reg <= valid_reg;
        end
    end

    // Fill count saturates at the filter length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(TAPS))
        else $error("fill count beyond filter length");

    // A valid rate only exists once the delay line is full
    a_valid_full: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (fill_reg == FILL_W'(TAPS)))
        else $error("rate valid before delay line full");

    // Tap sweep never runs past its drain cycle
    a_mac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (k_reg <= MAC_KW'(TAPS + 1)))
        else $error("tap counter overrun");

    // A new result only appears from the finish step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish step");

    // Input is refused while an item is in progress
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");

endmodule

// File: tb/sv/tb_dual_flow_meter_integrator.sv
`timescale 1ns / 100ps

module tb_dual_flow_meter_integrator;
    import dfmi_pkg::*;

    localparam int CLK_PERIOD         = 12;
    localparam int RESET_CYCLES       = 12;
    localparam int MAX_GAP            = 12;
    localparam int OUTPUT_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT        = 3000;
    localparam int SETTLE_CYCLES      = 40;
    localparam int REPORT_LIMIT       = 10;
    localparam int RANDOM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE    = 190;
    localparam int RAMP_ITEMS         = 60;

    localparam logic [1:0]        OP_UNUSED    = 2'd3;
    localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [15:0]       FREQ_MAX     = 16'hFFFF;

    typedef struct {
        logic signed [RATE_W-1:0] rate;
        logic signed [VOL_W-1:0]  volume;
        logic                     valid;
        logic                     flowing;
    } meter_reading_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // [15:0] inlet_freq, [31:16] return_freq
    logic [1:0]        s_tuser;   // [1:0] op
    logic              m_tvalid;
    logic              m_tready;
    logic [55:0]       m_tdata;   // [15:0] flow_rate, [47:16] flow_volume, [48] flowing
    logic [0:0]        m_tuser;   // [0] rate_valid
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_data;

    dual_flow_meter_integrator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // Meter state mirror
    int fir_tap [TAPS] = '{-582, -766, 715, 4454, 8776, 10714, 8776, 4454, 715, -766, -582};
    logic signed [DIFF_W-1:0] diff_hist [TAPS];
    int                       diff_head;
    int                       diff_count;
    bit                       flow_on;
    bit                       rate_ok;
    logic signed [RATE_W-1:0] rate_q;
    logic signed [VOL_W-1:0]  vol_q;
    logic [CFG_W-1:0] off_thr, on_thr, reject_thr, gain_inlet, gain_return, step_q16;

    meter_reading_t expected_readings [$];

    int mismatches;
    int stall_cycles = 0;
    bit idle_en;
    bit hold_output_req;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic int draw_gap();
        return idle_en ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    task automatic mirror_reset();
        foreach (diff_hist[i]) diff_hist[i] = '0;
        diff_head   = 0;
        diff_count  = 0;
        flow_on     = 1'b0;
        rate_ok     = 1'b0;
        rate_q      = '0;
        vol_q       = '0;
        off_thr     = 16'd64;
        on_thr      = 16'd320;
        reject_thr  = 16'd19200;
        gain_inlet  = 16'd8192;
        gain_return = 16'd9101;
        step_q16    = 16'd6554;
    endtask

    // Advance the mirror by one item and queue the reading it reports
    task automatic predict_meter(input logic [1:0] op, input logic [15:0] fin,
                                 input logic [15:0] fret);
        longint scaled_in, scaled_ret, acc, r, delta, vol;
        int k;
        meter_reading_t rd;
        if (op == OP_SAMPLE && fin < reject_thr) begin
            if (flow_on && fin < off_thr)
                flow_on = 1'b0;
            else if (!flow_on && fin > on_thr)
                flow_on = 1'b1;
            scaled_in  = (longint'(fin) * longint'(gain_inlet) + 32768) >>> 16;
            scaled_ret = (longint'(fret) * longint'(gain_return) + 32768) >>> 16;
            diff_head = (diff_head + 1) % TAPS;
            diff_hist[diff_head] = DIFF_W'(scaled_in - scaled_ret);
            if (diff_count < TAPS)
                diff_count++;
            if (diff_count == TAPS) begin
                acc = 0;
                for (k = 0; k < TAPS; k++)
                    acc += longint'(fir_tap[k])
                           * longint'(diff_hist[(diff_head - k + TAPS) % TAPS]);
                r = (acc + 16384) >>> 15;
                if (r > 32767) r = 32767;
                if (r < -32768) r = -32768;
                rate_q = RATE_W'(r);
                delta = (longint'(rate_q) * longint'(step_q16) + 32768) >>> 16;
                vol = longint'(vol_q) + delta;
                if (vol > 64'sd2147483647) vol = 64'sd2147483647;
                if (vol < -64'sd2147483648) vol = -64'sd2147483648;
                vol_q = VOL_W'(vol);
                rate_ok = 1'b1;
            end
        end else if (op == OP_NO_SAMPLE) begin
            rate_ok = 1'b0;
            flow_on = 1'b0;
        end else if (op == OP_CLR_VOL) begin
            vol_q = '0;
        end
        rd.rate    = rate_q;
        rd.volume  = vol_q;
        rd.valid   = rate_ok;
        rd.flowing = flow_on;
        expected_readings.push_back(rd);
    endtask

    // One input transfer, expectation queued on acceptance
    task automatic send_item(input logic [1:0] op, input logic [15:0] fin,
                             input logic [15:0] fret);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {fret, fin};
        do @(posedge aclk); while (!s_tready);
        predict_meter(op, fin, fret);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_readings.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_OFF_THR:   off_thr     = value;
            REG_ON_THR:    on_thr      = value;
            REG_REJECT:    reject_thr  = value;
            REG_IN_GAIN:   gain_inlet  = value;
            REG_RET_GAIN:  gain_return = value;
            REG_TIME_STEP: step_q16    = value;
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [15:0] off_v, input logic [15:0] on_v,
                                  input logic [15:0] rej_v, input logic [15:0] gin_v,
                                  input logic [15:0] gret_v, input logic [15:0] step_v);
        write_reg(REG_OFF_THR, off_v);
        write_reg(REG_ON_THR, on_v);
        write_reg(REG_REJECT, rej_v);
        write_reg(REG_IN_GAIN, gin_v);
        write_reg(REG_RET_GAIN, gret_v);
        write_reg(REG_TIME_STEP, step_v);
    endtask

    function automatic logic [15:0] near_value(input logic [15:0] center);
        int v;
        v = int'(center) + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // Inlet frequency biased toward accepted samples and the hysteresis edges
    function automatic logic [15:0] pick_inlet();
        int unsigned top;
        top = (reject_thr == 0) ? 0 : reject_thr - 1;
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, top));
            1:       return near_value(on_thr);
            2:       return near_value(off_thr);
            default: return 16'($urandom_range(0, (top < 2000) ? top : 2000));
        endcase
    endfunction

    function automatic logic [15:0] pick_return();
        return $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                    : 16'($urandom_range(0, 3000));
    endfunction

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            send_item(OP_SAMPLE, pick_inlet(), pick_return());
        else if (pick < 84)
            send_item(OP_SAMPLE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        else if (pick < 91)
            send_item(OP_NO_SAMPLE, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
        else if (pick < 96)
            send_item(OP_CLR_VOL, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        else
            send_item(OP_UNUSED, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    // Result sink: random stalls, plus one long hold when asked
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_output_req) begin
                hold_output_req = 1'b0;
                m_tready <= 1'b0;
                repeat (OUTPUT_HOLD_CYCLES) @(posedge aclk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endtask

    // Compare every result transfer against the oldest expected reading
    always @(posedge aclk) begin : result_check
        meter_reading_t rd;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: result with nothing expected, m_tdata %h", m_tdata);
            end else begin
                rd = expected_readings.pop_front();
                check_field("flow_rate", rd.rate, $signed(m_tdata[15:0]));
                check_field("flow_volume", rd.volume, $signed(m_tdata[47:16]));
                check_field("flowing", rd.flowing, m_tdata[48]);
                check_field("rate_valid", rd.valid, m_tuser[0]);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("dual_flow_meter_integrator regression: fail");
            $finish;
        end
    end

    // Operations, hysteresis edges, rejection and filter fill at reset settings
    task automatic test_directed_ops();
        send_item(OP_NO_SAMPLE, 16'd0, 16'd0);
        send_item(OP_UNUSED, FREQ_MAX, FREQ_MAX);
        send_item(OP_CLR_VOL, 16'd0, 16'd0);
        send_item(OP_SAMPLE, 16'd19200, 16'd100);      // at the reject limit
        send_item(OP_SAMPLE, FREQ_MAX, FREQ_MAX);
        send_item(OP_SAMPLE, 16'd321, 16'd0);          // flowing sets
        send_item(OP_SAMPLE, 16'd320, 16'd100);
        send_item(OP_SAMPLE, 16'd64, 16'd200);         // stays set
        send_item(OP_SAMPLE, 16'd63, 16'd0);           // flowing clears
        send_item(OP_SAMPLE, 16'd320, 16'd0);
        send_item(OP_SAMPLE, 16'd19199, FREQ_MAX);
        send_item(OP_SAMPLE, 16'd0, FREQ_MAX);
        send_item(OP_SAMPLE, 16'd1000, 16'd500);
        send_item(OP_SAMPLE, 16'd5000, 16'd0);
        send_item(OP_SAMPLE, 16'd12000, 16'd3000);
        send_item(OP_SAMPLE, 16'd19199, 16'd0);        // delay line now full
        send_item(OP_SAMPLE, 16'd800, 16'd800);
        send_item(OP_NO_SAMPLE, 16'd5, 16'd5);
        send_item(OP_SAMPLE, 16'd2000, 16'd100);
        send_item(OP_CLR_VOL, 16'd0, 16'd0);
        send_item(OP_UNUSED, 16'd0, 16'd0);
        send_item(OP_SAMPLE, 16'd40, 16'd20000);
        wait_drained();
    endtask

    // All-zero and all-max settings, rate clipping both ways, unmapped indexes
    task automatic test_config_extremes();
        write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (12) send_random_item();
        wait_drained();
        write_settings(FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX);
        repeat (30) begin
            if ($urandom_range(0, 3) != 0)
                send_item(OP_SAMPLE, 16'hFFFE - 16'($urandom_range(0, 3)),
                          16'($urandom_range(0, 65535)));
            else
                send_random_item();
        end
        wait_drained();
        write_reg(REG_IN_GAIN, 16'd0);
        repeat (30) send_item(OP_SAMPLE, 16'($urandom_range(0, 65534)),
                              FREQ_MAX - 16'($urandom_range(0, 3)));
        wait_drained();
        write_reg(REG_SPARE_LO, FREQ_MAX);
        write_reg(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
        repeat (8) send_random_item();
        wait_drained();
        write_settings(16'd64, 16'd320, 16'd19200, 16'd8192, 16'd9101, 16'd6554);
    endtask

    // Long output hold while input keeps offering, then a full sender pause
    task automatic test_flow_control();
        hold_output_req = 1'b1;
        repeat (25) send_random_item();
        wait_drained();
        repeat (6) send_random_item();
        wait_drained();
        repeat (6) send_random_item();
        wait_drained();
    endtask

    task automatic load_random_settings(input bit wild);
        logic [15:0] lo;
        lo = 16'($urandom_range(0, 800));
        write_reg(REG_OFF_THR, wild ? 16'($urandom_range(0, 65535)) : lo);
        write_reg(REG_ON_THR, wild ? 16'($urandom_range(0, 65535))
                                   : lo + 16'($urandom_range(0, 800)));
        write_reg(REG_REJECT, wild ? 16'($urandom_range(0, 65535))
                                   : 16'($urandom_range(2000, 65535)));
        write_reg(REG_IN_GAIN, 16'($urandom_range(0, 65535)));
        write_reg(REG_RET_GAIN, 16'($urandom_range(0, 65535)));
        write_reg(REG_TIME_STEP, 16'($urandom_range(0, 65535)));
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_random_settings(phase == RANDOM_PHASES - 1);
            idle_en = (phase != 2);
            repeat (ITEMS_PER_PHASE) send_random_item();
            wait_drained();
        end
        idle_en = 1'b1;
    endtask

    // Rate held at its positive clip for a run of back-to-back samples, then pulled down
    task automatic test_volume_ramp();
        idle_en = 1'b0;
        write_settings(16'd64, 16'd320, FREQ_MAX, FREQ_MAX, 16'd0, FREQ_MAX);
        send_item(OP_CLR_VOL, 16'd0, 16'd0);
        repeat (RAMP_ITEMS) send_item(OP_SAMPLE, 16'hFFFE, 16'($urandom_range(0, 65535)));
        wait_drained();
        write_reg(REG_IN_GAIN, 16'd0);
        write_reg(REG_RET_GAIN, FREQ_MAX);
        idle_en = 1'b1;
        repeat (40) send_item(OP_SAMPLE, 16'($urandom_range(0, 65534)),
                              16'($urandom_range(0, 65535)));
        wait_drained();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_addr  <= '0;
        cfg_data  <= '0;
        mismatches      = 0;
        idle_en         = 1'b1;
        hold_output_req = 1'b0;
        mirror_reset();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_config_extremes();
        test_flow_control();
        test_random_traffic();
        test_volume_ramp();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("dual_flow_meter_integrator regression: pass");
        else
            $display("dual_flow_meter_integrator regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/dfmi_pkg.sv
rtl/core/dfmi_ram.sv
rtl/core/dual_flow_meter_integrator.sv
tb/sv/tb_dual_flow_meter_integrator.sv
